// ===== rtl/core/pbalc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbalc_pkg: shared types and constants of the block allocator
// Holds the command and flag structs that pass between the controller and
// the per-order list cells, the state encodings, and the status codes.
// ----------------------------------------------------------------------------
package pbalc_pkg;

    // Fixed field widths.
    localparam int OFF_W  = 32;
    localparam int SIZE_W = 11;
    localparam int STAT_W = 3;

    // Operation codes of an input transaction.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes of a result transaction.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_DOUBLE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_LIST_FULL = 3'd4;

    // Commands that the controller issues to one list cell.
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_SCAN,
        CMD_POP,
        CMD_PUSH,
        CMD_DELETE,
        CMD_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [OFF_W-1:0]   value;
    } t_cell_cmd;

    // Status that one cell reports back to the controller.
    typedef struct packed {
        logic busy;
        logic eq;
        logic adj;
        logic empty;
        logic full;
    } t_cell_flags;

    // Sequencer state of one cell.
    typedef enum logic [2:0] {
        C_IDLE,
        C_SCAN,
        C_SHDN,
        C_SHUP,
        C_PUTV
    } t_cell_state;

    // Controller state.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_WAIT,
        S_SCAN_WAIT,
        S_COMMIT_WAIT,
        S_RESULT
    } t_state;

endpackage

// ===== rtl/core/pbalc_cell.sv =====
// ----------------------------------------------------------------------------
// pbalc_cell: free list of one order
// Keeps a sorted list of block start offsets in a local memory together with
// its fill count, and runs scans, pops, pushes and shifting inserts/deletes.
// ----------------------------------------------------------------------------
module pbalc_cell
    import pbalc_pkg::*;
#(
    parameter int ORDER      = 0,
    parameter int MAX_ORDER  = 10,
    parameter int LIST_DEPTH = 64,
    localparam int AW = $clog2(LIST_DEPTH),
    localparam int CW = $clog2(LIST_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_cmd        i_cmd,
    input  logic [CW-1:0]    i_pos,
    output t_cell_flags      o_flags,
    output logic [CW-1:0]    o_pos,
    output logic [OFF_W-1:0] o_data
);

    localparam logic [OFF_W:0] BLK_SIZE = (OFF_W+1)'(1) << ORDER;
    localparam logic           MERGE_OK = (ORDER < MAX_ORDER);

    logic [OFF_W-1:0] r_mem [LIST_DEPTH];
    logic [OFF_W-1:0] r_rd;

    t_cell_state      r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_pos, n_pos;
    logic [OFF_W-1:0] r_val, n_val;
    logic             r_eq, n_eq;
    logic             r_adj, n_adj;

    logic             we, re;
    logic [AW-1:0]    wa, ra;
    logic [OFF_W-1:0] wd;
    logic [CW-1:0]    cnt_m1, idx_p1, idx_p2, pos_p1;

    assign cnt_m1 = r_cnt - CW'(1);
    assign idx_p1 = CW'(r_idx) + CW'(1);
    assign idx_p2 = CW'(r_idx) + CW'(2);
    assign pos_p1 = i_pos + CW'(1);

    // Sequencer: next state, counters and memory access.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_val   = r_val;
        n_eq    = r_eq;
        n_adj   = r_adj;
        we      = 1'b0;
        wa      = '0;
        wd      = r_val;
        re      = 1'b0;
        ra      = '0;
        unique case (r_state)
            C_IDLE: begin
                case (i_cmd.op)
                    CMD_SCAN: begin
                        n_val = i_cmd.value;
                        n_eq  = 1'b0;
                        n_adj = 1'b0;
                        n_pos = r_cnt;
                        if (r_cnt != '0) begin
                            re      = 1'b1;
                            ra      = '0;
                            n_idx   = '0;
                            n_state = C_SCAN;
                        end
                    end
                    CMD_POP: begin
                        re    = 1'b1;
                        ra    = cnt_m1[AW-1:0];
                        n_cnt = cnt_m1;
                    end
                    CMD_PUSH: begin
                        we    = 1'b1;
                        wa    = r_cnt[AW-1:0];
                        wd    = i_cmd.value;
                        n_cnt = r_cnt + CW'(1);
                    end
                    CMD_DELETE: begin
                        if (pos_p1 >= r_cnt) begin
                            n_cnt = cnt_m1;
                        end else begin
                            re      = 1'b1;
                            ra      = pos_p1[AW-1:0];
                            n_idx   = i_pos[AW-1:0];
                            n_state = C_SHDN;
                        end
                    end
                    CMD_INSERT: begin
                        n_val = i_cmd.value;
                        n_pos = i_pos;
                        if (i_pos == r_cnt) begin
                            we    = 1'b1;
                            wa    = i_pos[AW-1:0];
                            wd    = i_cmd.value;
                            n_cnt = r_cnt + CW'(1);
                        end else begin
                            re      = 1'b1;
                            ra      = cnt_m1[AW-1:0];
                            n_idx   = cnt_m1[AW-1:0];
                            n_state = C_SHUP;
                        end
                    end
                    default: ;
                endcase
            end
            // Walk up the list until the first entry not below the offset, or its end.
            C_SCAN: begin
                if (r_rd >= r_val) begin
                    n_pos   = CW'(r_idx);
                    n_eq    = (r_rd == r_val);
                    n_adj   = MERGE_OK &&
                              (({1'b0, r_val} + BLK_SIZE) == {1'b0, r_rd});
                    n_state = C_IDLE;
                end else if (idx_p1 == r_cnt) begin
                    n_pos   = r_cnt;
                    n_state = C_IDLE;
                end else begin
                    re    = 1'b1;
                    ra    = idx_p1[AW-1:0];
                    n_idx = idx_p1[AW-1:0];
                end
            end
            // Close the gap of a removed entry, one move per cycle.
            C_SHDN: begin
                we = 1'b1;
                wa = r_idx;
                wd = r_rd;
                if (idx_p2 == r_cnt) begin
                    n_cnt   = cnt_m1;
                    n_state = C_IDLE;
                end else begin
                    re    = 1'b1;
                    ra    = idx_p2[AW-1:0];
                    n_idx = idx_p1[AW-1:0];
                end
            end
            // Open a gap for a new entry, moving from the tail down.
            C_SHUP: begin
                we = 1'b1;
                wa = idx_p1[AW-1:0];
                wd = r_rd;
                if (CW'(r_idx) == r_pos) begin
                    n_state = C_PUTV;
                end else begin
                    re    = 1'b1;
                    ra    = r_idx - AW'(1);
                    n_idx = r_idx - AW'(1);
                end
            end
            C_PUTV: begin
                we      = 1'b1;
                wa      = r_pos[AW-1:0];
                wd      = r_val;
                n_cnt   = r_cnt + CW'(1);
                n_state = C_IDLE;
            end
            default: n_state = C_IDLE;
        endcase
    end

    // List memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rd <= r_mem[ra];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_val <= n_val;
        r_eq  <= n_eq;
        r_adj <= n_adj;
    end

    assign o_flags.busy  = (r_state != C_IDLE);
    assign o_flags.eq    = r_eq;
    assign o_flags.adj   = r_adj;
    assign o_flags.empty = (r_cnt == '0);
    assign o_flags.full  = (r_cnt == CW'(LIST_DEPTH));
    assign o_pos         = r_pos;
    assign o_data        = r_rd;

endmodule

// ===== rtl/core/power_of_two_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// power_of_two_block_allocator_top: power-of-two block allocator
// Controller over a row of per-order free list cells.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An allocate gets the popped offset
// from one memory read, and a split writes all lower halves in parallel. A
// free scans every list, then inserts into the highest order that the merge
// chain reaches and deletes the merging entries from the orders below it in
// the chain; every cell runs its scan and shift in parallel over its own
// memory, one entry per cycle. The lists start empty after reset with no
// clearing pass, since only entries below each fill count are ever read.
// ----------------------------------------------------------------------------
module power_of_two_block_allocator_top
    import pbalc_pkg::*;
#(
    parameter int MAX_ORDER  = 10,
    parameter int LIST_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_operation,
    input  logic [SIZE_W-1:0] i_block_count,
    input  logic [OFF_W-1:0]  i_block_offset,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [OFF_W-1:0]  o_granted_offset,
    output logic [SIZE_W-1:0] o_granted_size
);

    localparam int NUM = MAX_ORDER + 1;
    localparam int OW  = $clog2(NUM);
    localparam int CW  = $clog2(LIST_DEPTH + 1);

    t_cell_cmd        cell_cmd     [NUM];
    logic [CW-1:0]    cell_pos_in  [NUM];
    t_cell_flags      cell_flg     [NUM];
    logic [CW-1:0]    cell_pos     [NUM];
    logic [OFF_W-1:0] cell_data    [NUM];

    t_state              r_state, n_state;
    logic                r_op;
    logic [OFF_W-1:0]    r_off;
    logic [OW-1:0]       r_ord;
    logic                r_bad;
    logic [OW-1:0]       r_k, n_k;
    logic [STAT_W-1:0]   r_res_stat, n_res_stat;
    logic [OFF_W-1:0]    r_res_off, n_res_off;
    logic [SIZE_W-1:0]   r_res_size, n_res_size;

    logic                acc_in;
    logic [OW-1:0]       acc_ord;
    logic                acc_fit;
    logic                all_idle;
    logic [NUM-1:0]      reach;
    logic [OW-1:0]       fin;
    logic                load_out;

    // Row of per-order cells.
    for (genvar g = 0; g < NUM; g++) begin : g_cell
        pbalc_cell #(
            .ORDER      (g),
            .MAX_ORDER  (MAX_ORDER),
            .LIST_DEPTH (LIST_DEPTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cell_cmd[g]),
            .i_pos   (cell_pos_in[g]),
            .o_flags (cell_flg[g]),
            .o_pos   (cell_pos[g]),
            .o_data  (cell_data[g])
        );
    end

    assign o_stall = (r_state != S_IDLE);
    assign acc_in  = i_valid && !o_stall;

    // Order of the request: smallest fit for allocate, exact match for free.
    always_comb begin
        acc_ord = '0;
        acc_fit = 1'b0;
        for (int j = MAX_ORDER; j >= 0; j--) begin
            if (i_operation == OP_ALLOC) begin
                if (32'(i_block_count) <= (32'd1 << j)) begin
                    acc_ord = OW'(j);
                    acc_fit = 1'b1;
                end
            end else if (32'(i_block_count) == (32'd1 << j)) begin
                acc_ord = OW'(j);
                acc_fit = 1'b1;
            end
        end
    end

    // All cells finished their command.
    always_comb begin
        all_idle = 1'b1;
        for (int j = 0; j < NUM; j++) begin
            if (cell_flg[j].busy) begin
                all_idle = 1'b0;
            end
        end
    end

    // Merge chain: an order is reached while every order from the request's order up to it merges.
    always_comb begin
        reach = '0;
        fin   = r_ord;
        for (int j = 0; j < NUM; j++) begin
            if (j == int'(r_ord)) begin
                reach[j] = 1'b1;
            end else if (j > int'(r_ord)) begin
                reach[j] = reach[j-1] && cell_flg[j-1].adj;
            end
            if (reach[j]) begin
                fin = OW'(j);
            end
        end
    end

    // Controller: next state, cell commands and result.
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_res_stat = r_res_stat;
        n_res_off  = r_res_off;
        n_res_size = r_res_size;
        load_out   = 1'b0;
        for (int j = 0; j < NUM; j++) begin
            cell_cmd[j].op    = CMD_NOP;
            cell_cmd[j].value = r_off;
            cell_pos_in[j]    = cell_pos[j];
        end
        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res_stat = ST_OK;
                n_res_off  = '0;
                n_res_size = '0;
                if (r_bad) begin
                    n_res_stat = ST_BAD_SIZE;
                    n_state    = S_RESULT;
                end else if (r_op == OP_ALLOC) begin
                    n_res_stat = ST_NO_SPACE;
                    n_state    = S_RESULT;
                    for (int j = MAX_ORDER; j >= 0; j--) begin
                        if (j >= int'(r_ord) && !cell_flg[j].empty) begin
                            n_k        = OW'(j);
                            n_res_stat = ST_OK;
                            n_state    = S_POP_WAIT;
                        end
                    end
                    if (n_state == S_POP_WAIT) begin
                        cell_cmd[n_k].op = CMD_POP;
                    end
                end else begin
                    for (int j = 0; j < NUM; j++) begin
                        cell_cmd[j].op = CMD_SCAN;
                    end
                    n_state = S_SCAN_WAIT;
                end
            end
            // Popped block known: grant the top piece, keep the lower halves.
            S_POP_WAIT: begin
                if (all_idle) begin
                    for (int j = 0; j < NUM; j++) begin
                        if (j >= int'(r_ord) && j < int'(r_k)) begin
                            cell_cmd[j].op    = CMD_PUSH;
                            cell_cmd[j].value = cell_data[r_k] +
                                OFF_W'((33'd1 << r_k) - (33'd1 << (j + 1)));
                        end
                    end
                    n_res_off  = cell_data[r_k] +
                                 OFF_W'((33'd1 << r_k) - (33'd1 << r_ord));
                    n_res_size = SIZE_W'(33'd1 << r_ord);
                    n_state    = S_RESULT;
                end
            end
            // Scans done: check the final order, then merge and insert.
            S_SCAN_WAIT: begin
                if (all_idle) begin
                    if (cell_flg[fin].eq) begin
                        n_res_stat = ST_DOUBLE;
                        n_state    = S_RESULT;
                    end else if (cell_flg[fin].full) begin
                        n_res_stat = ST_LIST_FULL;
                        n_state    = S_RESULT;
                    end else begin
                        for (int j = 0; j < NUM; j++) begin
                            if (j == int'(fin)) begin
                                cell_cmd[j].op = CMD_INSERT;
                            end else if (reach[j]) begin
                                cell_cmd[j].op = CMD_DELETE;
                            end
                        end
                        n_state = S_COMMIT_WAIT;
                    end
                end
            end
            S_COMMIT_WAIT: begin
                if (all_idle) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!o_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request and result registers.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_op  <= i_operation;
            r_off <= i_block_offset;
            r_ord <= acc_ord;
            r_bad <= !acc_fit || (i_block_count == '0);
        end
        r_k        <= n_k;
        r_res_stat <= n_res_stat;
        r_res_off  <= n_res_off;
        r_res_size <= n_res_size;
    end

    // Output register for the result transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (load_out) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_status         <= r_res_stat;
            o_granted_offset <= r_res_off;
            o_granted_size   <= r_res_size;
        end
    end

endmodule
